FILE: rtl/lsc_pkg.sv
// Shared types and constants for the line segment clipper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // deltas and distances need one more bit than a coordinate
    localparam int DW  = COORD_BITS + 1;
    // magnitude of a delta or distance fits in COORD_BITS unsigned bits
    localparam int MW  = COORD_BITS;
    // quotient bits kept before saturation
    localparam int QW  = FRAC_BITS + 1;
    // quotient bits resolved per divider stage
    localparam int BPS = 4;
    localparam int DIV_STAGES = (QW + BPS - 1) / BPS;
    // signed width that holds -1 .. 2^FRAC_BITS + 1
    localparam int RW  = FRAC_BITS + 3;
    // product of u (unsigned, FRAC_BITS+1) and a signed delta
    localparam int PW  = FRAC_BITS + 2 + DW;
    localparam int SW  = PW + 1;

    localparam int NUM_EDGES = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         delta_t;
    typedef logic        [FRAC_BITS:0]    u_t;

    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_X_MAX = 2'd1,
        REG_Y_MIN = 2'd2,
        REG_Y_MAX = 2'd3
    } cfg_index_t;

    localparam coord_t RST_X_MIN = coord_t'(0);
    localparam coord_t RST_X_MAX = coord_t'(1023);
    localparam coord_t RST_Y_MIN = coord_t'(0);
    localparam coord_t RST_Y_MAX = coord_t'(1023);

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } in_t;

    typedef struct packed {
        logic   visible;
        coord_t out_start_x;
        coord_t out_start_y;
        coord_t out_end_x;
        coord_t out_end_y;
    } out_t;

endpackage

FILE: rtl/lsc_div.sv
// Pipelined unsigned divider: floor(num * 2^FRAC_BITS / den), sat flag.
// Depends on lsc_pkg. Its registers advance only while en is high.
`timescale 1ns / 1ps

module lsc_div (
    input  logic                    clk,
    input  logic                    en,
    input  logic [lsc_pkg::MW-1:0]  num,
    input  logic [lsc_pkg::MW-1:0]  den,
    output logic [lsc_pkg::QW-1:0]  quo,
    output logic                    sat
);
    import lsc_pkg::*;

    logic [MW:0]   rem_reg  [DIV_STAGES];
    logic [QW-1:0] quo_reg  [DIV_STAGES];
    logic [MW-1:0] den_reg  [DIV_STAGES];
    logic          sat_reg  [DIV_STAGES];

    logic [MW:0]   rem_next [DIV_STAGES];
    logic [QW-1:0] quo_next [DIV_STAGES];
    logic [MW-1:0] den_next [DIV_STAGES];
    logic          sat_next [DIV_STAGES];

    always_comb
    begin
        logic [MW:0]   rem;
        logic [QW-1:0] q;
        logic [MW-1:0] d;
        int            j;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem = {1'b0, num};
                q   = '0;
                d   = den;
                // quotient of 2^(QW) or more only matters as "too big"
                sat_next[s] = ({1'b0, num} >= {den, 1'b0});
            end
            else
            begin
                rem = rem_reg[s-1];
                q   = quo_reg[s-1];
                d   = den_reg[s-1];
                sat_next[s] = sat_reg[s-1];
            end
            for (int b = 0; b < BPS; b++)
            begin
                j = s * BPS + b;
                if (j < QW)
                begin
                    if (j > 0)
                        rem = {rem[MW-1:0], 1'b0};
                    if (rem >= {1'b0, d})
                    begin
                        rem = rem - {1'b0, d};
                        q   = {q[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q   = {q[QW-2:0], 1'b0};
                    end
                end
            end
            rem_next[s] = rem;
            quo_next[s] = q;
            den_next[s] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_next[s];
                sat_reg[s] <= sat_next[s];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];
    assign sat = sat_reg[DIV_STAGES-1];

endmodule

FILE: rtl/line_segment_clipper.sv
// Top level of the Liang-Barsky line segment clipper.
// Depends on lsc_pkg and lsc_div.
`timescale 1ns / 1ps

// Clips one segment per transaction against the configured window and
// accepts a new segment every cycle while no result waits at the output.
// A segment passes stage A, the four parallel pipelined dividers (BPS
// quotient bits per stage), stage U, stage M and the output register.
// The whole pipeline advances together and stalls only while a result
// waits at the output. Window registers may be written any time the block
// is idle; each min/max pair is ordered internally.
module line_segment_clipper (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lsc_pkg::in_t         in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsc_pkg::out_t        out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  lsc_pkg::cfg_index_t  cfg_index,
    input  lsc_pkg::coord_t      cfg_data
);
    import lsc_pkg::*;

    typedef struct packed {
        coord_t                sx;
        coord_t                sy;
        delta_t                dx;
        delta_t                dy;
        logic [NUM_EDGES-1:0]  pneg;
        logic [NUM_EDGES-1:0]  pzero;
        logic [NUM_EDGES-1:0]  qneg;
    } meta_t;

    function automatic coord_t move_coord(coord_t c, logic signed [PW-1:0] prod);
        logic signed [SW-1:0] sum;
        sum = $signed({{(SW-COORD_BITS-FRAC_BITS){c[COORD_BITS-1]}}, c, {FRAC_BITS{1'b0}}})
            + $signed({prod[PW-1], prod});
        // truncate toward zero
        if (sum[SW-1])
            sum = sum + SW'((1 << FRAC_BITS) - 1);
        return sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    endfunction

    logic en;

    // window registers
    coord_t wx_a_reg, wx_b_reg, wy_a_reg, wy_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_a_reg <= RST_X_MIN;
            wx_b_reg <= RST_X_MAX;
            wy_a_reg <= RST_Y_MIN;
            wy_b_reg <= RST_Y_MAX;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_MIN: wx_a_reg <= cfg_data;
                REG_X_MAX: wx_b_reg <= cfg_data;
                REG_Y_MIN: wy_a_reg <= cfg_data;
                REG_Y_MAX: wy_b_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // ---------------- stage A: deltas and edge terms ----------------
    logic   a_valid_reg;
    coord_t a_sx_reg, a_sy_reg;
    delta_t a_dx_reg, a_dy_reg;
    delta_t a_p_reg [NUM_EDGES];
    delta_t a_q_reg [NUM_EDGES];

    coord_t xmin, xmax, ymin, ymax;
    delta_t sx_e, sy_e, dx_n, dy_n;
    delta_t p_n [NUM_EDGES];
    delta_t q_n [NUM_EDGES];

    always_comb
    begin
        xmin = (wx_a_reg < wx_b_reg) ? wx_a_reg : wx_b_reg;
        xmax = (wx_a_reg < wx_b_reg) ? wx_b_reg : wx_a_reg;
        ymin = (wy_a_reg < wy_b_reg) ? wy_a_reg : wy_b_reg;
        ymax = (wy_a_reg < wy_b_reg) ? wy_b_reg : wy_a_reg;
        sx_e = {in_data.start_x[COORD_BITS-1], in_data.start_x};
        sy_e = {in_data.start_y[COORD_BITS-1], in_data.start_y};
        dx_n = {in_data.end_x[COORD_BITS-1], in_data.end_x} - sx_e;
        dy_n = {in_data.end_y[COORD_BITS-1], in_data.end_y} - sy_e;
        // left, right, bottom, top
        p_n[0] = -dx_n;
        q_n[0] = sx_e - {xmin[COORD_BITS-1], xmin};
        p_n[1] = dx_n;
        q_n[1] = {xmax[COORD_BITS-1], xmax} - sx_e;
        p_n[2] = -dy_n;
        q_n[2] = sy_e - {ymin[COORD_BITS-1], ymin};
        p_n[3] = dy_n;
        q_n[3] = {ymax[COORD_BITS-1], ymax} - sy_e;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sx_reg <= in_data.start_x;
            a_sy_reg <= in_data.start_y;
            a_dx_reg <= dx_n;
            a_dy_reg <= dy_n;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                a_p_reg[e] <= p_n[e];
                a_q_reg[e] <= q_n[e];
            end
        end
    end

    // ---------------- divider stages ----------------
    logic [MW-1:0] abs_p [NUM_EDGES];
    logic [MW-1:0] abs_q [NUM_EDGES];
    logic [QW-1:0] quo   [NUM_EDGES];
    logic          sat   [NUM_EDGES];
    meta_t         meta_n;

    always_comb
    begin
        delta_t tp, tq;
        meta_n.sx = a_sx_reg;
        meta_n.sy = a_sy_reg;
        meta_n.dx = a_dx_reg;
        meta_n.dy = a_dy_reg;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            tp = a_p_reg[e][DW-1] ? -a_p_reg[e] : a_p_reg[e];
            tq = a_q_reg[e][DW-1] ? -a_q_reg[e] : a_q_reg[e];
            abs_p[e] = tp[MW-1:0];
            abs_q[e] = tq[MW-1:0];
            meta_n.pneg[e]  = a_p_reg[e][DW-1];
            meta_n.pzero[e] = (a_p_reg[e] == '0);
            meta_n.qneg[e]  = a_q_reg[e][DW-1];
        end
    end

    for (genvar e = 0; e < NUM_EDGES; e++)
    begin : g_div
        lsc_div u_div (
            .clk (clk),
            .en  (en),
            .num (abs_q[e]),
            .den (abs_p[e]),
            .quo (quo[e]),
            .sat (sat[e])
        );
    end

    meta_t meta_reg [DIV_STAGES];
    logic  mv_reg   [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_n;
            for (int s = 1; s < DIV_STAGES; s++)
                meta_reg[s] <= meta_reg[s-1];
        end
    end

    // ---------------- stage U: boundary tests ----------------
    logic   u_valid_reg, u_vis_reg;
    u_t     u_u1_reg, u_u2_reg;
    coord_t u_sx_reg, u_sy_reg;
    delta_t u_dx_reg, u_dy_reg;

    meta_t  md;
    logic   vis_n;
    logic signed [RW-1:0] lo, hi;

    always_comb
    begin
        logic signed [RW-1:0] r;
        logic [RW-1:0]        mag;
        md    = meta_reg[DIV_STAGES-1];
        lo    = '0;
        hi    = RW'(1 << FRAC_BITS);
        vis_n = 1'b1;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            // r clamped to -1 .. 2^FRAC_BITS+1, enough to decide every test
            if (sat[e] || ({{(RW-QW){1'b0}}, quo[e]} > RW'((1 << FRAC_BITS) + 1)))
                mag = RW'((1 << FRAC_BITS) + 1);
            else
                mag = {{(RW-QW){1'b0}}, quo[e]};
            if ((md.pneg[e] ^ md.qneg[e]) && (mag != '0))
                r = -RW'(1);
            else
                r = $signed(mag);
            if (md.pneg[e])
            begin
                if (r > hi)
                    vis_n = 1'b0;
                else if (r > lo)
                    lo = r;
            end
            else if (!md.pzero[e])
            begin
                if (r < lo)
                    vis_n = 1'b0;
                else if (r < hi)
                    hi = r;
            end
            else if (md.qneg[e])
            begin
                vis_n = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_vis_reg <= vis_n;
            u_u1_reg  <= lo[FRAC_BITS:0];
            u_u2_reg  <= hi[FRAC_BITS:0];
            u_sx_reg  <= md.sx;
            u_sy_reg  <= md.sy;
            u_dx_reg  <= md.dx;
            u_dy_reg  <= md.dy;
        end
    end

    // ---------------- stage M: products ----------------
    logic   m_valid_reg, m_vis_reg, m_move_s_reg, m_move_e_reg;
    coord_t m_sx_reg, m_sy_reg;
    delta_t m_dx_reg, m_dy_reg;
    logic signed [PW-1:0] m_psx_reg, m_psy_reg, m_pex_reg, m_pey_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_vis_reg    <= u_vis_reg;
            m_move_s_reg <= (u_u1_reg != '0);
            m_move_e_reg <= (u_u2_reg < u_t'(1 << FRAC_BITS));
            m_sx_reg     <= u_sx_reg;
            m_sy_reg     <= u_sy_reg;
            m_dx_reg     <= u_dx_reg;
            m_dy_reg     <= u_dy_reg;
            m_psx_reg    <= $signed({1'b0, u_u1_reg}) * u_dx_reg;
            m_psy_reg    <= $signed({1'b0, u_u1_reg}) * u_dy_reg;
            m_pex_reg    <= $signed({1'b0, u_u2_reg}) * u_dx_reg;
            m_pey_reg    <= $signed({1'b0, u_u2_reg}) * u_dy_reg;
        end
    end

    // ---------------- stage F: output register ----------------
    logic   out_valid_reg;
    out_t   out_data_reg, out_data_next;
    delta_t ex_w, ey_w;

    always_comb
    begin
        ex_w = {m_sx_reg[COORD_BITS-1], m_sx_reg} + m_dx_reg;
        ey_w = {m_sy_reg[COORD_BITS-1], m_sy_reg} + m_dy_reg;
        out_data_next.visible     = m_vis_reg;
        out_data_next.out_start_x = m_sx_reg;
        out_data_next.out_start_y = m_sy_reg;
        out_data_next.out_end_x   = ex_w[COORD_BITS-1:0];
        out_data_next.out_end_y   = ey_w[COORD_BITS-1:0];
        if (m_vis_reg && m_move_s_reg)
        begin
            out_data_next.out_start_x = move_coord(m_sx_reg, m_psx_reg);
            out_data_next.out_start_y = move_coord(m_sy_reg, m_psy_reg);
        end
        if (m_vis_reg && m_move_e_reg)
        begin
            out_data_next.out_end_x = move_coord(m_sx_reg, m_pex_reg);
            out_data_next.out_end_y = move_coord(m_sy_reg, m_pey_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++)
                mv_reg[s] <= 1'b0;
            u_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            mv_reg[0]     <= a_valid_reg;
            for (int s = 1; s < DIV_STAGES; s++)
                mv_reg[s] <= mv_reg[s-1];
            u_valid_reg   <= mv_reg[DIV_STAGES-1];
            m_valid_reg   <= u_valid_reg;
            out_valid_reg <= m_valid_reg;
        end
    end

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/lsc_checker.sv
// Port-level checks for line_segment_clipper, bound to the top level.
// Depends on lsc_pkg.
`timescale 1ns / 1ps

module lsc_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  lsc_pkg::in_t         in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  lsc_pkg::out_t        out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready
);
    import lsc_pkg::*;

    // a waiting input transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input changed while waiting");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // the pipeline only stalls on a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output backpressure");

    // a stall never drops the waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid)
        else $error("result lost during stall");

    // configuration writes are never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transaction refused");

endmodule

bind line_segment_clipper lsc_checker u_lsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

FILE: tb/tb_line_segment_clipper.sv
// Testbench for line_segment_clipper: directed and random segments against
// several clip windows, checked against an in-bench Liang-Barsky predictor.
// Depends on lsc_pkg and the clipper RTL.
`timescale 1ns / 1ps

module tb_line_segment_clipper;
    import lsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint U_ONE = longint'(1) << FRAC_BITS;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    coord_t     cfg_data;

    coord_t win_regs [4];
    out_t   clip_expected [$];
    int     mismatch_count;
    int     segments_sent;
    int     results_checked;
    int     visible_count;
    int     idle_cycles;
    bit     stall_enable;

    line_segment_clipper DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // One boundary test; returns 0 when the segment falls outside.
    function automatic bit boundary_test(longint p, longint q, ref longint lo,
                                         ref longint hi);
        longint r;
        if (p < 0)
        begin
            r = (q * U_ONE) / p;
            if (r > hi)
                return 0;
            if (r > lo)
                lo = r;
        end
        else if (p > 0)
        begin
            r = (q * U_ONE) / p;
            if (r < lo)
                return 0;
            if (r < hi)
                hi = r;
        end
        else if (q < 0)
            return 0;
        return 1;
    endfunction

    function automatic coord_t shift_point(longint c, longint u, longint d);
        longint v;
        v = (c * U_ONE + u * d) / U_ONE;
        return coord_t'(v);
    endfunction

    function automatic out_t clip_segment(in_t seg);
        out_t   res;
        longint sx, sy, ex, ey, dx, dy, u1, u2;
        longint xa, xb, ya, yb, xmin, xmax, ymin, ymax;
        sx = seg.start_x;
        sy = seg.start_y;
        ex = seg.end_x;
        ey = seg.end_y;
        xa = win_regs[REG_X_MIN];
        xb = win_regs[REG_X_MAX];
        ya = win_regs[REG_Y_MIN];
        yb = win_regs[REG_Y_MAX];
        xmin = xa < xb ? xa : xb;
        xmax = xa < xb ? xb : xa;
        ymin = ya < yb ? ya : yb;
        ymax = ya < yb ? yb : ya;
        dx = ex - sx;
        dy = ey - sy;
        u1 = 0;
        u2 = U_ONE;
        res.visible = 1'b0;
        res.out_start_x = seg.start_x;
        res.out_start_y = seg.start_y;
        res.out_end_x = seg.end_x;
        res.out_end_y = seg.end_y;
        if (boundary_test(-dx, sx - xmin, u1, u2) &&
            boundary_test(dx, xmax - sx, u1, u2) &&
            boundary_test(-dy, sy - ymin, u1, u2) &&
            boundary_test(dy, ymax - sy, u1, u2))
        begin
            res.visible = 1'b1;
            if (u2 < U_ONE)
            begin
                res.out_end_x = shift_point(sx, u2, dx);
                res.out_end_y = shift_point(sy, u2, dy);
            end
            if (u1 > 0)
            begin
                res.out_start_x = shift_point(sx, u1, dx);
                res.out_start_y = shift_point(sy, u1, dy);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_checked, what, got, want);
    endtask

    // valid stays high into a back-to-back transaction; it drops only in a gap
    task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        in_t seg;
        int  gap;
        seg = '{start_x: sx, start_y: sy, end_x: ex, end_y: ey};
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= seg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        clip_expected.push_back(clip_segment(seg));
        segments_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (clip_expected.size() != 0)
            @(posedge clk);
        repeat (DIV_STAGES + 8) @(posedge clk);
    endtask

    task automatic write_window(cfg_index_t idx, coord_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        win_regs[idx] = val;
    endtask

    task automatic set_window(coord_t x0, coord_t x1, coord_t y0, coord_t y1);
        wait_drain();
        write_window(REG_X_MIN, x0);
        write_window(REG_X_MAX, x1);
        write_window(REG_Y_MIN, y0);
        write_window(REG_Y_MAX, y1);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic coord_t pick_coord();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return coord_t'($urandom_range(0, 1300)) - coord_t'(150);
        else if (roll < 8)
            return coord_t'($urandom);
        else
            return $urandom_range(0, 1) ? coord_t'(16'sh7fff) : coord_t'(16'sh8000);
    endfunction

    // Result checker, one expectation per accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_t want;
            if (clip_expected.size() == 0)
            begin
                mismatch_count++;
                $display("MISMATCH unexpected result transaction");
            end
            else
            begin
                want = clip_expected.pop_front();
                if (out_data.visible !== want.visible)
                    report_mismatch("visible", out_data.visible, want.visible);
                if (out_data.out_start_x !== want.out_start_x)
                    report_mismatch("out_start_x", out_data.out_start_x, want.out_start_x);
                if (out_data.out_start_y !== want.out_start_y)
                    report_mismatch("out_start_y", out_data.out_start_y, want.out_start_y);
                if (out_data.out_end_x !== want.out_end_x)
                    report_mismatch("out_end_x", out_data.out_end_x, want.out_end_x);
                if (out_data.out_end_y !== want.out_end_y)
                    report_mismatch("out_end_y", out_data.out_end_y, want.out_end_y);
                if (want.visible)
                    visible_count++;
            end
            results_checked++;
        end
    end

    // Output-side stalls
    always @(posedge clk)
    begin
        if (!stall_enable)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) < 70);
    end

    // Watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_directed_reset_window();
        send_segment(10, 10, 500, 600);
        send_segment(-100, 500, 2000, 500);
        send_segment(500, -100, 500, 2000);
        send_segment(-50, -50, -10, 2000);
        send_segment(2000, 10, 2000, 20);
        send_segment(300, 300, 300, 300);
        send_segment(-5, 300, -5, 300);
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_segment(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_segment(1100, 500, -100, 500);
        send_segment(500, 1100, 500, -100);
        send_segment(0, 0, 1023, 1023);
        send_segment(-1, 1024, 1024, -1);
        send_segment(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_segment(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    endtask

    task automatic test_swapped_and_extreme_windows();
        set_window(1023, 0, 1023, 0);
        send_segment(-100, 500, 2000, 500);
        send_segment(-100, -100, 2000, 2000);
        set_window(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_segment(16'sh7fff, 0, 16'sh8000, 5);
        set_window(-200, -200, 50, 50);
        send_segment(-300, 50, 0, 50);
        send_segment(-200, -100, -200, 300);
        send_segment(-300, 0, 0, 100);
    endtask

    task automatic run_random(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            send_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            n++;
        end
    endtask

    task automatic test_random_windows();
        set_window(0, 1023, 0, 1023);
        run_random(500);
        set_window(900, -100, 1000, 50);
        run_random(400);
        set_window(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        run_random(300);
        set_window(coord_t'($urandom_range(0, 400)), coord_t'($urandom_range(500, 1100)),
                   coord_t'($urandom_range(0, 400)), coord_t'($urandom_range(500, 1100)));
        run_random(450);
        // long stretch with no stalls at the output
        stall_enable = 1'b0;
        run_random(300);
        stall_enable = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_MIN;
        cfg_data = '0;
        out_ready = 1'b0;
        stall_enable = 1'b1;
        mismatch_count = 0;
        segments_sent = 0;
        results_checked = 0;
        visible_count = 0;
        idle_cycles = 0;
        win_regs[REG_X_MIN] = RST_X_MIN;
        win_regs[REG_X_MAX] = RST_X_MAX;
        win_regs[REG_Y_MIN] = RST_Y_MIN;
        win_regs[REG_Y_MAX] = RST_Y_MAX;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reset_window();
        test_swapped_and_extreme_windows();
        test_random_windows();
        wait_drain();

        $display("Clipped %0d segments over eight window settings, %0d results checked, %0d visible.",
                 segments_sent, results_checked, visible_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
rtl/lsc_pkg.sv
rtl/lsc_div.sv
rtl/line_segment_clipper.sv
rtl/lsc_checker.sv
tb/tb_line_segment_clipper.sv
